// ===== design/date_add_days_weekday_macros.svh =====
// Assertion macros for the date advance block.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef DATE_ADD_DAYS_WEEKDAY_MACROS_SVH
`define DATE_ADD_DAYS_WEEKDAY_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DADW_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date_add_days_weekday: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define DADW_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date_add_days_weekday: next-cycle check failed");

`endif

// ===== design/dadw_pkg.sv =====
// Shared types, constants and calendar helpers for the date advance block.
// No dependencies.
package dadw_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int WDAY_W  = 3;
    localparam int ACC_W   = 17;   // start day plus day count
    localparam int CENT_W  = 7;    // year / 100 for valid years
    localparam int MUL_W   = 14;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int QUO7_W  = 11;   // weekday sum / 7

    localparam logic [COUNT_W-1:0] MAX_DAYS_ADD = 16'd65535;
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT   = 14'd9999;

    // Reciprocal multipliers: exact over the operand ranges used here.
    localparam logic [MUL_W-1:0] DIV100_MUL   = 14'd5243;
    localparam int               DIV100_SHIFT = 19;
    localparam logic [MUL_W-1:0] DIV7_MUL     = 14'd9363;
    localparam int               DIV7_SHIFT   = 16;

    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] M_APR = 4'd4;
    localparam logic [MONTH_W-1:0] M_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] M_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] M_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] M_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] M_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

    localparam logic [CENT_W-1:0] LAST_IN_CENT = 7'd99;
    localparam logic [DAY_W-1:0]  FEB_SHORT    = 5'd28;
    localparam logic [DAY_W-1:0]  FEB_LONG     = 5'd29;
    localparam logic [DAY_W-1:0]  MONTH_SHORT  = 5'd30;
    localparam logic [DAY_W-1:0]  MONTH_LONG   = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SPLIT,
        S_SUM,
        S_MUL7,
        S_FOLD,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             load;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    // Leap test from year bits, year mod 100 and year / 100.
    function automatic logic is_leap(input logic [1:0] y_low,
                                     input logic [CENT_W-1:0] rem,
                                     input logic [1:0] cent_low);
        return (y_low == 2'd0) && ((rem != '0) || (cent_low == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            M_FEB:                      len = leap ? FEB_LONG : FEB_SHORT;
            M_APR, M_JUN, M_SEP, M_NOV: len = MONTH_SHORT;
            default:                    len = MONTH_LONG;
        endcase
        return len;
    endfunction

    // Month offsets of the weekday formula.
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] ofs;
        unique case (m) inside
            M_JAN, M_MAY:        ofs = 3'd0;
            M_AUG:               ofs = 3'd1;
            M_MAR, M_NOV:        ofs = 3'd2;
            M_FEB, M_JUN:        ofs = 3'd3;
            M_SEP, M_DEC:        ofs = 3'd4;
            M_APR, M_JUL:        ofs = 3'd5;
            M_OCT:               ofs = 3'd6;
            default:             ofs = 3'd0;
        endcase
        return ofs;
    endfunction

    // Residue mod 7 of a 6-bit value by a short chain of subtractions.
    function automatic logic [WDAY_W-1:0] mod7_small(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= 6'd35) t = t - 6'd35;
        if (t >= 6'd28) t = t - 6'd28;
        if (t >= 6'd14) t = t - 6'd14;
        if (t >= 6'd7)  t = t - 6'd7;
        return t[WDAY_W-1:0];
    endfunction

endpackage

// ===== design/dadw_mul.sv =====
// Shared multiplier with registered product for the date advance block.
// Depends on dadw_pkg.
module dadw_mul (
    input  logic                     clk,
    input  dadw_pkg::mul_req_t       req,
    output logic [dadw_pkg::PROD_W-1:0] prod
);
    import dadw_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/date_add_days_weekday.sv =====
// Gregorian date advance with weekday. One item at a time: after a start beat
// the block runs the setup states S_DIV, S_SPLIT, S_SUM, S_MUL7 and S_FOLD (year
// split into century and remainder with the shared multiplier, date check,
// weekday base by multiply-and-fold), then S_WALK, which crosses one month
// boundary per step until the day fits or the year would pass 9999. The month
// walk takes most of the time. An invalid start date goes from S_SPLIT straight
// to S_DONE. The result beat is held in output registers until taken;
// start_ready is low meanwhile. Depends on dadw_pkg, dadw_mul and date_add_days_weekday_macros.svh.
`include "date_add_days_weekday_macros.svh"

module date_add_days_weekday (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start_valid,
    output logic                          start_ready,
    input  logic [dadw_pkg::YEAR_W-1:0]   start_year,
    input  logic [dadw_pkg::MONTH_W-1:0]  start_month,
    input  logic [dadw_pkg::DAY_W-1:0]    start_day,
    input  logic [dadw_pkg::COUNT_W-1:0]  days_to_add,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          date_valid,
    output logic [dadw_pkg::YEAR_W-1:0]   result_year,
    output logic [dadw_pkg::MONTH_W-1:0]  result_month,
    output logic [dadw_pkg::DAY_W-1:0]    result_day,
    output logic [dadw_pkg::WDAY_W-1:0]   weekday
);
    import dadw_pkg::*;

    state_t state_reg, state_next;

    logic [YEAR_W-1:0]  y_reg, y_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [ACC_W-1:0]   d_reg, d_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [CENT_W-1:0]  c_reg, c_next;
    logic [CENT_W-1:0]  r_reg, r_next;
    logic [YEAR_W-1:0]  s_reg, s_next;
    logic [WDAY_W-1:0]  w_reg, w_next;

    logic               ok_reg, ok_next;
    logic [YEAR_W-1:0]  ry_reg, ry_next;
    logic [MONTH_W-1:0] rm_reg, rm_next;
    logic [DAY_W-1:0]   rd_reg, rd_next;
    logic [WDAY_W-1:0]  wd_reg, wd_next;

    mul_req_t          mul_req;
    logic [PROD_W-1:0] prod;

    dadw_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Year split from the product of y * (2^19 / 100).
    logic [CENT_W-1:0] split_c;
    logic [YEAR_W-1:0] split_hund;
    logic [CENT_W-1:0] split_r;
    logic              start_ok;

    assign split_c    = prod[DIV100_SHIFT +: CENT_W];
    assign split_hund = y_reg - YEAR_W'(split_c) * YEAR_W'(100);
    assign split_r    = split_hund[CENT_W-1:0];
    assign start_ok   = (y_reg != '0) && (y_reg <= YEAR_LIMIT)
                     && (m_reg != '0) && (m_reg <= M_DEC)
                     && (d_reg != '0)
                     && (d_reg <= ACC_W'(month_len(m_reg,
                            is_leap(y_reg[1:0], split_r, split_c[1:0]))));

    // Month walk step.
    logic [DAY_W-1:0] walk_len;
    logic             walk_fit;
    logic             walk_wrap;
    logic             walk_over;

    assign walk_len  = month_len(m_reg, is_leap(y_reg[1:0], r_reg, c_reg[1:0]));
    assign walk_fit  = (d_reg <= ACC_W'(walk_len));
    assign walk_wrap = (m_reg == M_DEC);
    assign walk_over = walk_wrap && (y_reg == YEAR_LIMIT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start_valid) state_next = S_DIV;
            S_DIV:   state_next = S_SPLIT;
            S_SPLIT: state_next = start_ok ? S_SUM : S_DONE;
            S_SUM:   state_next = S_MUL7;
            S_MUL7:  state_next = S_FOLD;
            S_FOLD:  state_next = S_WALK;
            S_WALK:  if (walk_fit || walk_over) state_next = S_DONE;
            S_DONE:  if (result_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        start_ready  = (state_reg == S_IDLE);
        result_valid = (state_reg == S_DONE);
    end

    // Datapath
    always_comb
    begin
        logic [YEAR_W-1:0] yy;
        logic [CENT_W-1:0] cp;
        logic [QUO7_W-1:0] q7;
        logic [YEAR_W-1:0] fold;
        logic [DAY_W-1:0]  len_ofs;
        logic [WDAY_W:0]   w_sum;

        y_next  = y_reg;
        m_next  = m_reg;
        d_next  = d_reg;
        n_next  = n_reg;
        c_next  = c_reg;
        r_next  = r_reg;
        s_next  = s_reg;
        w_next  = w_reg;
        ok_next = ok_reg;
        ry_next = ry_reg;
        rm_next = rm_reg;
        rd_next = rd_reg;
        wd_next = wd_reg;
        mul_req = '{load: 1'b0, a: y_reg, b: DIV100_MUL};

        yy      = y_reg;
        cp      = c_reg;
        q7      = prod[DIV7_SHIFT +: QUO7_W];
        fold    = s_reg - YEAR_W'(q7) * YEAR_W'(7);
        len_ofs = walk_len - FEB_SHORT;
        w_sum   = {1'b0, w_reg} + len_ofs[WDAY_W:0];

        case (state_reg)
            S_IDLE:
            begin
                y_next = start_year;
                m_next = start_month;
                d_next = ACC_W'(start_day);
                n_next = (days_to_add > MAX_DAYS_ADD) ? MAX_DAYS_ADD : days_to_add;
            end
            S_DIV:
            begin
                mul_req = '{load: 1'b1, a: y_reg, b: DIV100_MUL};
            end
            S_SPLIT:
            begin
                c_next = split_c;
                r_next = split_r;
                if (!start_ok)
                begin
                    ok_next = 1'b0;
                    ry_next = '0;
                    rm_next = '0;
                    rd_next = '0;
                    wd_next = '0;
                end
            end
            S_SUM:
            begin
                // Weekday base of day zero of the start month.
                if (m_reg < M_MAR)
                begin
                    yy = y_reg - YEAR_W'(1);
                    if (r_reg == '0)
                    begin
                        cp = c_reg - CENT_W'(1);
                    end
                end
                s_next = yy + (yy >> 2) - YEAR_W'(cp) + YEAR_W'(cp >> 2)
                       + YEAR_W'(month_offset(m_reg));
            end
            S_MUL7:
            begin
                mul_req = '{load: 1'b1, a: s_reg, b: DIV7_MUL};
            end
            S_FOLD:
            begin
                w_next = fold[WDAY_W-1:0];
                d_next = d_reg + ACC_W'(n_reg);
            end
            S_WALK:
            begin
                if (walk_fit)
                begin
                    ok_next = 1'b1;
                    ry_next = y_reg;
                    rm_next = m_reg;
                    rd_next = d_reg[DAY_W-1:0];
                    wd_next = mod7_small(6'(w_reg) + 6'(d_reg[DAY_W-1:0]));
                end
                else if (walk_over)
                begin
                    ok_next = 1'b0;
                    ry_next = '0;
                    rm_next = '0;
                    rd_next = '0;
                    wd_next = '0;
                end
                else
                begin
                    // Advance to the next month; day zero moves by its length.
                    d_next = d_reg - ACC_W'(walk_len);
                    w_next = (w_sum >= 4'd7) ? WDAY_W'(w_sum - 4'd7) : w_sum[WDAY_W-1:0];
                    if (walk_wrap)
                    begin
                        m_next = M_JAN;
                        y_next = y_reg + YEAR_W'(1);
                        if (r_reg == LAST_IN_CENT)
                        begin
                            r_next = '0;
                            c_next = c_reg + CENT_W'(1);
                        end
                        else
                        begin
                            r_next = r_reg + CENT_W'(1);
                        end
                    end
                    else
                    begin
                        m_next = m_reg + MONTH_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg  <= y_next;
        m_reg  <= m_next;
        d_reg  <= d_next;
        n_reg  <= n_next;
        c_reg  <= c_next;
        r_reg  <= r_next;
        s_reg  <= s_next;
        w_reg  <= w_next;
        ok_reg <= ok_next;
        ry_reg <= ry_next;
        rm_reg <= rm_next;
        rd_reg <= rd_next;
        wd_reg <= wd_next;
    end

    assign date_valid   = ok_reg;
    assign result_year  = ry_reg;
    assign result_month = rm_reg;
    assign result_day   = rd_reg;
    assign weekday      = wd_reg;

    logic good_fields;
    logic zero_fields;

    assign good_fields = (result_month != '0) && (result_month <= M_DEC)
                      && (result_day != '0) && (weekday <= 3'd6)
                      && (result_year != '0);
    assign zero_fields = (result_year == '0) && (result_month == '0)
                      && (result_day == '0) && (weekday == '0);

    `DADW_ASSERT_IMP(a_one_side, result_valid, !start_ready)
    `DADW_ASSERT_NXT(a_busy_after_start, start_valid && start_ready, !start_ready)
    `DADW_ASSERT_IMP(a_good_fields, result_valid && date_valid, good_fields)
    `DADW_ASSERT_IMP(a_bad_fields, result_valid && !date_valid, zero_fields)

endmodule
